// File: hw/rtl/csv_field_tokenizer_defines.svh
// assertion macros for the csv field tokenizer
// used by the top level; no other dependencies
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define CSVFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvft assertion failed");

// next-cycle implication, disabled in reset
`define CSVFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvft assertion failed");

`else

`define CSVFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSVFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/csvft_pkg.sv
// shared types, codes and result builders for the csv field tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csvft_pkg;

    // limits
    localparam int FIELD_CHARS_MAX = 255;
    localparam int COLUMNS_MAX     = 256;
    localparam logic [7:0] LEN_LIMIT   = 8'(FIELD_CHARS_MAX);
    localparam logic [7:0] COLUMN_LAST = 8'(COLUMNS_MAX - 1);

    // queue between parser and result stage
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

    // byte codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_BELL    = 8'h07;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_T = 8'h74;

    // result kinds
    localparam logic [1:0] KIND_CONTENT   = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // field classes
    localparam logic [1:0] TYPE_INTEGER = 2'd0;
    localparam logic [1:0] TYPE_FLOAT   = 2'd1;
    localparam logic [1:0] TYPE_EMPTY   = 2'd2;
    localparam logic [1:0] TYPE_TEXT    = 2'd3;

    // error codes
    localparam logic ERR_BREAK_IN_QUOTE = 1'b0;
    localparam logic ERR_BAD_AFTER_QUOTE = 1'b1;

    // parser modes
    typedef enum logic [2:0] {
        MODE_ROW,
        MODE_FIELD,
        MODE_PLAIN,
        MODE_QUOTE,
        MODE_ESC,
        MODE_CLOSED,
        MODE_SKIP
    } t_mode;

    // one result transaction
    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         char_byte;
        logic [1:0]         field_type;
        logic [7:0]         field_length;
        logic               truncated;
        logic [7:0]         column_index;
        logic signed [31:0] int_value;
        logic               error_code;
    } t_result;

    // results caused by one input byte
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic t_result f_content(input logic [7:0] b);
        t_result r;
        r = '0;
        r.kind = KIND_CONTENT;
        r.char_byte = b;
        return r;
    endfunction

    function automatic t_result f_row_end();
        t_result r;
        r = '0;
        r.kind = KIND_ROW_END;
        return r;
    endfunction

    function automatic t_result f_error(input logic code);
        t_result r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    // classify the finished field and build its end record
    function automatic t_result f_field_end(
        input logic        digits_only,
        input logic [1:0]  dot_count,
        input logic [7:0]  length_count,
        input logic        trunc,
        input logic        minus_seen,
        input logic [31:0] acc,
        input logic [7:0]  column
    );
        t_result r;
        r = '0;
        r.kind = KIND_FIELD_END;
        r.field_length = length_count;
        r.truncated = trunc;
        r.column_index = column;
        if (!digits_only || dot_count[1]) begin
            r.field_type = TYPE_TEXT;
        end else if (dot_count[0]) begin
            r.field_type = TYPE_FLOAT;
        end else if ((length_count == 8'd0) && !trunc && !minus_seen) begin
            r.field_type = TYPE_EMPTY;
        end else begin
            r.field_type = TYPE_INTEGER;
            r.int_value = minus_seen ? (32'd0 - acc) : acc;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/csvft_front.sv
// parser front: accepts bytes, tracks row/field state, builds result entries
// depends on csvft_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvft_front
    import csvft_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_in_byte,
    input  wire t_q_status  i_q_status,
    output logic            o_q_push,
    output t_entry          o_entry
);

    t_mode       r_mode,    n_mode;
    logic [7:0]  r_col,     n_col;
    logic [7:0]  r_len,     n_len;
    logic        r_touched, n_touched;
    logic        r_minus,   n_minus;
    logic        r_digits,  n_digits;
    logic [1:0]  r_dot,     n_dot;
    logic [31:0] r_acc,     n_acc;
    logic        r_trunc,   n_trunc;

    logic accept;
    logic line_end;
    logic is_digit;

    // decoded actions for this byte
    logic       touch_set;
    logic       digits_clr;
    logic       do_classify;
    logic       cls_first;
    logic       do_error;
    logic       err_code;
    logic       put0_en;
    logic [7:0] put0_byte;
    logic       put1_en;
    logic [7:0] put1_byte;
    logic       do_field_end;
    logic       do_row_end;

    t_result    v_res [2];
    logic [1:0] v_cnt;

    assign accept   = i_push && !i_q_status.full;
    assign line_end = (i_in_byte == CH_CR) || (i_in_byte == CH_LF) || (i_in_byte == CH_NUL);
    assign is_digit = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_NINE);

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_ROW, MODE_FIELD: begin
                if (line_end) begin
                    n_mode = MODE_ROW;
                end else if ((i_in_byte == CH_SPACE) || (i_in_byte == CH_COMMA)) begin
                    n_mode = MODE_FIELD;
                end else if (i_in_byte == CH_QUOTE) begin
                    n_mode = MODE_QUOTE;
                end else begin
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_PLAIN: begin
                if (line_end) begin
                    n_mode = MODE_ROW;
                end else if (i_in_byte == CH_COMMA) begin
                    n_mode = MODE_FIELD;
                end
            end
            MODE_QUOTE: begin
                if (line_end) begin
                    n_mode = MODE_ROW;
                end else if (i_in_byte == CH_QUOTE) begin
                    n_mode = MODE_CLOSED;
                end else if (i_in_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end
            end
            MODE_ESC: begin
                n_mode = line_end ? MODE_ROW : MODE_QUOTE;
            end
            MODE_CLOSED: begin
                if (line_end) begin
                    n_mode = MODE_ROW;
                end else if (i_in_byte == CH_COMMA) begin
                    n_mode = MODE_FIELD;
                end else begin
                    n_mode = MODE_SKIP;
                end
            end
            default: begin
                n_mode = line_end ? MODE_ROW : MODE_SKIP;
            end
        endcase
    end

    // action decode per mode
    always_comb begin
        touch_set    = 1'b0;
        digits_clr   = 1'b0;
        do_classify  = 1'b0;
        cls_first    = 1'b0;
        do_error     = 1'b0;
        err_code     = ERR_BREAK_IN_QUOTE;
        put0_en      = 1'b0;
        put0_byte    = i_in_byte;
        put1_en      = 1'b0;
        put1_byte    = i_in_byte;
        do_field_end = 1'b0;
        do_row_end   = 1'b0;
        case (r_mode)
            MODE_ROW, MODE_FIELD: begin
                if (line_end) begin
                    if (r_mode == MODE_FIELD) begin
                        do_field_end = r_touched;
                        do_row_end   = 1'b1;
                    end
                end else if (i_in_byte == CH_SPACE) begin
                    touch_set = 1'b1;
                end else if (i_in_byte == CH_COMMA) begin
                    do_field_end = 1'b1;
                end else if (i_in_byte == CH_QUOTE) begin
                    touch_set  = 1'b1;
                    digits_clr = 1'b1;
                end else begin
                    touch_set   = 1'b1;
                    do_classify = 1'b1;
                    cls_first   = 1'b1;
                    put0_en     = 1'b1;
                end
            end
            MODE_PLAIN: begin
                if (line_end) begin
                    do_field_end = 1'b1;
                    do_row_end   = 1'b1;
                end else if (i_in_byte == CH_COMMA) begin
                    do_field_end = 1'b1;
                end else begin
                    do_classify = 1'b1;
                    put0_en     = 1'b1;
                end
            end
            MODE_QUOTE: begin
                if (line_end) begin
                    do_error   = 1'b1;
                    do_row_end = 1'b1;
                end else if ((i_in_byte != CH_QUOTE) && (i_in_byte != CH_BSLASH)) begin
                    put0_en = 1'b1;
                end
            end
            MODE_ESC: begin
                if (line_end) begin
                    do_error   = 1'b1;
                    do_row_end = 1'b1;
                end else begin
                    put0_en = 1'b1;
                    case (i_in_byte)
                        CH_QUOTE:   put0_byte = CH_QUOTE;
                        CH_LOWER_T: put0_byte = CH_TAB;
                        CH_LOWER_A: put0_byte = CH_BELL;
                        CH_APOS:    put0_byte = CH_APOS;
                        default: begin
                            // unknown escape keeps the backslash and the byte
                            put0_byte = CH_BSLASH;
                            put1_en   = 1'b1;
                        end
                    endcase
                end
            end
            MODE_CLOSED: begin
                if (line_end) begin
                    do_field_end = 1'b1;
                    do_row_end   = 1'b1;
                end else if (i_in_byte == CH_COMMA) begin
                    do_field_end = 1'b1;
                end else begin
                    do_error = 1'b1;
                    err_code = ERR_BAD_AFTER_QUOTE;
                end
            end
            default: begin
                do_row_end = line_end;
            end
        endcase
    end

    // field state update and result slots, in emission order
    always_comb begin
        n_col     = r_col;
        n_len     = r_len;
        n_touched = r_touched || touch_set;
        n_minus   = r_minus;
        n_digits  = r_digits && !digits_clr;
        n_dot     = r_dot;
        n_acc     = r_acc;
        n_trunc   = r_trunc;
        v_cnt     = 2'd0;
        v_res[0]  = '0;
        v_res[1]  = '0;

        // numeric classification, dropped bytes included
        if (do_classify) begin
            if (cls_first && (i_in_byte == CH_MINUS)) begin
                n_minus = 1'b1;
            end else if (is_digit) begin
                n_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                      + {28'd0, i_in_byte[3:0]};
            end else if (i_in_byte == CH_DOT) begin
                if (!r_dot[1]) begin
                    n_dot = r_dot + 2'd1;
                end
            end else begin
                n_digits = 1'b0;
            end
        end

        if (do_error) begin
            v_res[v_cnt[0]] = f_error(err_code);
            v_cnt = v_cnt + 2'd1;
        end

        // content bytes up to the length limit
        if (put0_en) begin
            if (n_len < LEN_LIMIT) begin
                n_len = n_len + 8'd1;
                v_res[v_cnt[0]] = f_content(put0_byte);
                v_cnt = v_cnt + 2'd1;
            end else begin
                n_trunc = 1'b1;
            end
        end
        if (put1_en) begin
            if (n_len < LEN_LIMIT) begin
                n_len = n_len + 8'd1;
                v_res[v_cnt[0]] = f_content(put1_byte);
                v_cnt = v_cnt + 2'd1;
            end else begin
                n_trunc = 1'b1;
            end
        end

        if (do_field_end) begin
            v_res[v_cnt[0]] = f_field_end(n_digits, n_dot, n_len, n_trunc, n_minus,
                                          n_acc, n_col);
            v_cnt = v_cnt + 2'd1;
            if (n_col < COLUMN_LAST) begin
                n_col = n_col + 8'd1;
            end
        end
        if (do_row_end) begin
            v_res[v_cnt[0]] = f_row_end();
            v_cnt = v_cnt + 2'd1;
            n_col = 8'd0;
        end

        // clear field state after any field or row end
        if (do_field_end || do_row_end) begin
            n_len     = 8'd0;
            n_touched = 1'b0;
            n_minus   = 1'b0;
            n_digits  = 1'b1;
            n_dot     = 2'd0;
            n_acc     = 32'd0;
            n_trunc   = 1'b0;
        end
    end

    // entry toward the queue
    always_comb begin
        o_q_push       = accept && (v_cnt != 2'd0);
        o_entry.two    = v_cnt[1];
        o_entry.first  = v_res[0];
        o_entry.second = v_res[1];
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_ROW;
            r_col     <= 8'd0;
            r_len     <= 8'd0;
            r_touched <= 1'b0;
            r_minus   <= 1'b0;
            r_digits  <= 1'b1;
            r_dot     <= 2'd0;
            r_acc     <= 32'd0;
            r_trunc   <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_col     <= n_col;
            r_len     <= n_len;
            r_touched <= n_touched;
            r_minus   <= n_minus;
            r_digits  <= n_digits;
            r_dot     <= n_dot;
            r_acc     <= n_acc;
            r_trunc   <= n_trunc;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/csvft_queue.sv
// short entry queue between parser front and result back
// depends on csvft_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvft_queue
    import csvft_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_entry    i_entry,
    input  wire logic      i_pop,
    output t_entry         o_entry,
    output t_q_status      o_status
);

    t_entry                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_COUNT_W-1:0] r_count,  n_count;

    // status and head entry
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QUEUE_COUNT_W'(QUEUE_DEPTH));
    assign o_entry        = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/csvft_back.sv
// result back: splits queue entries into single results behind an output register
// depends on csvft_pkg
`timescale 1ns / 1ps
`default_nettype none

module csvft_back
    import csvft_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_entry    i_entry,
    input  wire t_q_status i_q_status,
    output logic           o_q_pop,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_result        o_result
);

    logic    r_valid;
    logic    r_pend_valid;
    t_result r_res;
    t_result r_pend;
    logic    out_free;

    // output slot frees when empty or taken this cycle
    assign out_free = !r_valid || i_pop;
    assign o_q_pop  = out_free && !r_pend_valid && !i_q_status.empty;
    assign o_empty  = !r_valid;
    assign o_result = r_res;

    // control: second result of an entry goes before the next entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_valid      <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_valid      <= !i_q_status.empty;
                r_pend_valid <= !i_q_status.empty && i_entry.two;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_res <= r_pend;
            end else if (!i_q_status.empty) begin
                r_res  <= i_entry.first;
                r_pend <= i_entry.second;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/csv_field_tokenizer.sv
// top level of the csv field tokenizer: parser front, entry queue, result back
// depends on csvft_pkg, csvft_front, csvft_queue, csvft_back, defines header
//
// channel  | direction | handshake        | payload
// ---------+-----------+------------------+---------------------------------------------
// input    | in        | push / full      | i_in_byte
// result   | out       | pop / empty      | o_kind .. o_error_code, one port per field
//
// one byte per cycle is accepted while full is low; the parser updates in a single step.
// a byte causing two results (field end and row end, error and row end, or an
// undecoded escape) sends them out one after the other; the four-entry queue
// absorbs short bursts of these. results reach the ports through the output register.
// reset is synchronous and active low: parser to row start, queue and output empty.
// full rises when the queue holds four entries, either because the result port is
// stalled or because the bytes cause more than one result per cycle on average.
`timescale 1ns / 1ps
`default_nettype none

`include "csv_field_tokenizer_defines.svh"

module csv_field_tokenizer
    import csvft_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         i_in_byte,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              o_kind,
    output logic [7:0]              o_char_byte,
    output logic [1:0]              o_field_type,
    output logic [7:0]              o_field_length,
    output logic                    o_truncated,
    output logic [7:0]              o_column_index,
    output logic signed [31:0]      o_int_value,
    output logic                    o_error_code
);

    t_entry    front_entry;
    t_entry    head_entry;
    t_q_status q_status;
    t_result   result;
    logic      q_push;
    logic      q_pop;
    logic      res_not_end;

    // front part: byte accept and parse
    csvft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_entry    (front_entry)
    );

    // entry queue
    csvft_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (front_entry),
        .i_pop    (q_pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    // back part: result serialization
    csvft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (head_entry),
        .i_q_status (q_status),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (result)
    );

    // result ports
    assign full           = q_status.full;
    assign o_kind         = result.kind;
    assign o_char_byte    = result.char_byte;
    assign o_field_type   = result.field_type;
    assign o_field_length = result.field_length;
    assign o_truncated    = result.truncated;
    assign o_column_index = result.column_index;
    assign o_int_value    = result.int_value;
    assign o_error_code   = result.error_code;

    // a waiting result that is not a field end
    assign res_not_end = !empty && (o_kind != KIND_FIELD_END);

    // a pushed entry is in the queue on the next cycle
    `CSVFT_ASSERT_NXT(a_push_lands, i_clk, i_rst_n, q_push, !q_status.empty)
    // a full queue implies the output register is occupied
    `CSVFT_ASSERT_IMP(a_full_holds_out, i_clk, i_rst_n, q_status.full, !empty)
    // only field end transactions carry a length
    `CSVFT_ASSERT_IMP(a_len_at_end, i_clk, i_rst_n, res_not_end, o_field_length == 8'd0)

endmodule

`default_nettype wire
